// ----- design/ebml_pkg.sv -----
// ----------------------------------------------------------------------------
// ebml_pkg
// Shared types, constants and decode helpers for the EBML element header
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ebml_pkg;

  localparam int NUM_CONT       = 8;
  localparam int CFG_IDX_W      = $clog2(NUM_CONT);
  localparam int MAX_ID_BYTES   = 4;
  localparam int MAX_SIZE_BYTES = 8;

  // Reset values of the container ID registers, entry 0 in the low word.
  localparam logic [NUM_CONT-1:0][31:0] CONT_ID_RESET = {
    32'h0000_00E1,  // Audio
    32'h0000_00E0,  // Video
    32'h0000_00AE,  // TrackEntry
    32'h1549_A966,  // Segment Info
    32'h1654_AE6B,  // Tracks
    32'h1F43_B675,  // Cluster
    32'h1853_8067,  // Segment
    32'h1A45_DFA3   // EBML header
  };

  typedef enum logic [1:0] {
    PH_ID_FIRST = 2'd0,
    PH_ID_MORE  = 2'd1,
    PH_SIZE     = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  elem_id;
    logic [2:0]   id_length;
    logic [55:0]  data_size;
    logic [3:0]   size_length;
    logic         size_unknown;
    logic         is_container;
    logic [7:0]   payload_byte;
    logic         payload_last;
  } result_t;

  // Length given by the leading zeros of a first vint byte: 1..8, 9 for zero.
  function automatic logic [3:0] vint_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    if (b[7])      n = 4'd1;
    else if (b[6]) n = 4'd2;
    else if (b[5]) n = 4'd3;
    else if (b[4]) n = 4'd4;
    else if (b[3]) n = 4'd5;
    else if (b[2]) n = 4'd6;
    else if (b[1]) n = 4'd7;
    else if (b[0]) n = 4'd8;
    return n;
  endfunction

  // All value bits set for a size of n bytes: 7*n ones.
  function automatic logic [55:0] size_ones(input logic [3:0] n);
    logic [55:0] m;
    case (n)
      4'd1:    m = 56'h00_0000_0000_007F;
      4'd2:    m = 56'h00_0000_0000_3FFF;
      4'd3:    m = 56'h00_0000_001F_FFFF;
      4'd4:    m = 56'h00_0000_0FFF_FFFF;
      4'd5:    m = 56'h00_0007_FFFF_FFFF;
      4'd6:    m = 56'h00_03FF_FFFF_FFFF;
      4'd7:    m = 56'h01_FFFF_FFFF_FFFF;
      4'd8:    m = 56'hFF_FFFF_FFFF_FFFF;
      default: m = 56'h0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/ebml_element_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ebml_element_header_parser_core
// Byte-at-a-time EBML element header parser with container descent and
// payload pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Stream bytes enter on in_valid/in_byte and are taken on a clock edge with
//   in_valid high and in_stall low. Each byte yields zero or one result beat
//   on the out_ channel: a header when the last size byte arrives, a payload
//   byte for elements that are not descended into, or an error for a bad
//   first ID or size byte. Bytes in the middle of a header give no beat.
//   The container ID table is written on cfg_valid with cfg_index and
//   cfg_data; cfg_ready is always high. Write it only while the parser idles.
//   An accepted byte's result beat is registered in the output or skid
//   register, and one byte is taken every cycle while in_stall is low. All
//   decoding is combinational between the header state and output registers.
//   A two-entry output buffer (output register plus skid register) lets the
//   parser take a byte while a result waits; in_stall rises only once the
//   skid register is full, so a stalled receiver costs at most two beats of
//   buffering before the input is held off.
//   Reset clears the buffer, returns the parser to the first ID byte and
//   loads the default container IDs.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_element_header_parser_core
  import ebml_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Stream input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  // Results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_kind,
  output logic [31:0]               out_elem_id,
  output logic [2:0]                out_id_length,
  output logic [55:0]               out_data_size,
  output logic [3:0]                out_size_length,
  output logic                      out_size_unknown,
  output logic                      out_is_container,
  output logic [7:0]                out_payload_byte,
  output logic                      out_payload_last,
  // Configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Configuration registers
  logic [NUM_CONT-1:0][31:0] cont_id_r, cont_id_nxt;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] id_accum_r, id_accum_nxt;
  logic [2:0]  id_len_r, id_len_nxt;
  logic [2:0]  id_left_r, id_left_nxt;
  logic [55:0] size_accum_r, size_accum_nxt;
  logic [3:0]  size_len_r, size_len_nxt;
  logic [3:0]  size_left_r, size_left_nxt;
  logic [55:0] payload_left_r, payload_left_nxt;

  // Output buffer
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  // Decode of the current byte
  logic        accept;
  logic [3:0]  vlen;
  logic        id_err;
  logic        size_first;
  logic        size_err;
  logic [55:0] size_acc_new;
  logic [3:0]  size_len_new;
  logic [3:0]  size_left_new;
  logic [2:0]  id_left_new;
  logic        hdr_done;
  logic        unknown;
  logic        cont;
  logic        pay_last;
  result_t     res;
  logic        res_valid;
  logic        out_ready;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    vlen          = vint_len(in_byte);
    id_err        = (vlen > 4'(MAX_ID_BYTES));
    size_first    = (size_len_r == 4'd0);
    size_err      = size_first && (vlen > 4'(MAX_SIZE_BYTES));
    id_left_new   = id_left_r - 3'd1;
    if (size_first) begin
      size_len_new  = vlen;
      size_left_new = vlen - 4'd1;
      size_acc_new  = {48'h0, in_byte & ((8'h80 >> 3'(vlen - 4'd1)) - 8'd1)};
    end else begin
      size_len_new  = size_len_r;
      size_left_new = size_left_r - 4'd1;
      size_acc_new  = {size_accum_r[47:0], in_byte};
    end
    hdr_done = (phase_r == PH_SIZE) && !size_err && (size_left_new == 4'd0);
    unknown  = (size_acc_new == size_ones(size_len_new));
    cont     = unknown;
    for (int i = 0; i < NUM_CONT; i++) begin
      if (cont_id_r[i] == id_accum_r) cont = 1'b1;
    end
    pay_last = (payload_left_r <= 56'd1);
  end

  // Next state
  always_comb begin
    phase_nxt        = phase_r;
    id_accum_nxt     = id_accum_r;
    id_len_nxt       = id_len_r;
    id_left_nxt      = id_left_r;
    size_accum_nxt   = size_accum_r;
    size_len_nxt     = size_len_r;
    size_left_nxt    = size_left_r;
    payload_left_nxt = payload_left_r;
    if (accept) begin
      case (phase_r)
        PH_ID_FIRST: begin
          if (!id_err) begin
            id_accum_nxt = {24'h0, in_byte};
            id_len_nxt   = 3'(vlen);
            id_left_nxt  = 3'(vlen - 4'd1);
            size_len_nxt = 4'd0;
            phase_nxt    = (vlen != 4'd1) ? PH_ID_MORE : PH_SIZE;
          end
        end
        PH_ID_MORE: begin
          id_accum_nxt = {id_accum_r[23:0], in_byte};
          id_left_nxt  = id_left_new;
          if (id_left_new == 3'd0) begin
            size_len_nxt = 4'd0;
            phase_nxt    = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (size_err) begin
            phase_nxt = PH_ID_FIRST;
          end else begin
            size_accum_nxt = size_acc_new;
            size_len_nxt   = size_len_new;
            size_left_nxt  = size_left_new;
            if (hdr_done) begin
              if (cont || size_acc_new == 56'd0) begin
                phase_nxt = PH_ID_FIRST;
              end else begin
                payload_left_nxt = size_acc_new;
                phase_nxt        = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            payload_left_nxt = 56'd0;
            phase_nxt        = PH_ID_FIRST;
          end else begin
            payload_left_nxt = payload_left_r - 56'd1;
          end
        end
        default: phase_nxt = PH_ID_FIRST;
      endcase
    end
  end

  // Result of the current byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (phase_r)
      PH_ID_FIRST: begin
        if (id_err) begin
          res.kind  = KIND_ERROR;
          res_valid = accept;
        end
      end
      PH_SIZE: begin
        if (size_err) begin
          res.kind  = KIND_ERROR;
          res_valid = accept;
        end else if (hdr_done) begin
          res.kind         = KIND_HEADER;
          res.elem_id      = id_accum_r;
          res.id_length    = id_len_r;
          res.data_size    = size_acc_new;
          res.size_length  = size_len_new;
          res.size_unknown = unknown;
          res.is_container = cont;
          res_valid        = accept;
        end
      end
      PH_PAYLOAD: begin
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = in_byte;
        res.payload_last = pay_last;
        res_valid        = accept;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // Output register with skid stage. No byte is taken while the skid is full.
  always_comb begin
    out_ready      = !out_valid_r || !out_stall;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_nxt       = res;
      out_valid_nxt = res_valid;
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    cont_id_nxt = cont_id_r;
    if (cfg_valid && cfg_ready) begin
      cont_id_nxt[cfg_index] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_id_r      <= CONT_ID_RESET;
      phase_r        <= PH_ID_FIRST;
      id_accum_r     <= '0;
      id_len_r       <= '0;
      id_left_r      <= '0;
      size_accum_r   <= '0;
      size_len_r     <= '0;
      size_left_r    <= '0;
      payload_left_r <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      cont_id_r      <= cont_id_nxt;
      phase_r        <= phase_nxt;
      id_accum_r     <= id_accum_nxt;
      id_len_r       <= id_len_nxt;
      id_left_r      <= id_left_nxt;
      size_accum_r   <= size_accum_nxt;
      size_len_r     <= size_len_nxt;
      size_left_r    <= size_left_nxt;
      payload_left_r <= payload_left_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_elem_id      = out_r.elem_id;
  assign out_id_length    = out_r.id_length;
  assign out_data_size    = out_r.data_size;
  assign out_size_length  = out_r.size_length;
  assign out_size_unknown = out_r.size_unknown;
  assign out_is_container = out_r.is_container;
  assign out_payload_byte = out_r.payload_byte;
  assign out_payload_last = out_r.payload_last;

  // The skid register only fills behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  // Reset leaves no result beat behind.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("result beat present right after reset");

  // Payload phase always has at least one byte left to pass.
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> payload_left_r != 56'd0)
    else $error("payload phase with no bytes left");

  // Only payload beats carry a last mark.
  a_last_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.payload_last |-> out_r.kind == KIND_PAYLOAD)
    else $error("last mark on a beat that is not payload");

endmodule

`default_nettype wire

// ----- dv/ebml_element_header_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebml_element_header_parser_core_test
// Self-checking bench for the EBML element header parser. Byte streams of
// well-formed elements with random content, mixed with malformed headers,
// are fed in under random sender gaps and receiver stalls. A predictor
// follows the same streams and every result beat is compared field by field.
// ----------------------------------------------------------------------------
module ebml_element_header_parser_core_test;
  import ebml_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [31:0]          out_elem_id;
  logic [2:0]           out_id_length;
  logic [55:0]          out_data_size;
  logic [3:0]           out_size_length;
  logic                 out_size_unknown;
  logic                 out_is_container;
  logic [7:0]           out_payload_byte;
  logic                 out_payload_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = 32'h0;

  ebml_element_header_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_elem_id      (out_elem_id),
    .out_id_length    (out_id_length),
    .out_data_size    (out_data_size),
    .out_size_length  (out_size_length),
    .out_size_unknown (out_size_unknown),
    .out_is_container (out_is_container),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // Parser state as the predictor sees it.
  phase_t      ph;
  logic [31:0] id_acc;
  logic [2:0]  id_len;
  logic [2:0]  id_left;
  logic [55:0] size_acc;
  logic [3:0]  size_len;
  logic [3:0]  size_left;
  logic [55:0] pay_left;
  logic [31:0] cont_ids [NUM_CONT];
  logic [31:0] next_table [NUM_CONT];

  result_t pending_beats [$];

  bit idle_on = 1'b1;
  int mismatches = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int n_headers = 0;
  int n_payload = 0;
  int n_errors = 0;
  int tables_loaded = 0;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Length marked by the leading zeros of a first vint byte, 9 for a zero byte.
  function automatic logic [3:0] lead_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 8; i++)
      if (b[i]) n = 4'(8 - i);
    return n;
  endfunction

  function automatic logic [55:0] value_ones(input int n);
    logic [63:0] t;
    t = (64'd1 << (7 * n)) - 64'd1;
    return t[55:0];
  endfunction

  function automatic bit table_hit(input logic [31:0] id);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_CONT; i++)
      if (cont_ids[i] == id) hit = 1'b1;
    return hit;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_CONT; i++) cont_ids[i] = CONT_ID_RESET[i];
    ph        = PH_ID_FIRST;
    id_acc    = '0;
    id_len    = '0;
    id_left   = '0;
    size_acc  = '0;
    size_len  = '0;
    size_left = '0;
    pay_left  = '0;
  endtask

  task automatic log_beat(input result_t r);
    pending_beats.push_back(r);
    case (r.kind)
      KIND_HEADER:  n_headers++;
      KIND_PAYLOAD: n_payload++;
      default:      n_errors++;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t     r;
    logic [3:0]  n;
    logic [55:0] ones;
    bit          bad_size;
    bit          unknown;
    r = '0;
    bad_size = 1'b0;
    case (ph)
      PH_ID_FIRST: begin
        n = lead_len(b);
        if (n > MAX_ID_BYTES) begin
          r.kind = KIND_ERROR;
          log_beat(r);
        end else begin
          id_acc   = {24'h0, b};
          id_len   = n[2:0];
          id_left  = n[2:0] - 3'd1;
          size_len = 4'd0;
          ph       = (id_left != 3'd0) ? PH_ID_MORE : PH_SIZE;
        end
      end
      PH_ID_MORE: begin
        id_acc  = {id_acc[23:0], b};
        id_left = id_left - 3'd1;
        if (id_left == 3'd0) begin
          size_len = 4'd0;
          ph       = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (size_len == 4'd0) begin
          n = lead_len(b);
          if (n > MAX_SIZE_BYTES) begin
            bad_size = 1'b1;
          end else begin
            size_len  = n;
            size_acc  = {48'h0, b & ((8'h80 >> (n - 4'd1)) - 8'h01)};
            size_left = n - 4'd1;
          end
        end else begin
          size_acc  = {size_acc[47:0], b};
          size_left = size_left - 4'd1;
        end
        if (bad_size) begin
          r.kind = KIND_ERROR;
          ph     = PH_ID_FIRST;
          log_beat(r);
        end else if (size_left == 4'd0) begin
          ones           = value_ones(size_len);
          unknown        = (size_acc == ones);
          r.kind         = KIND_HEADER;
          r.elem_id      = id_acc;
          r.id_length    = id_len;
          r.data_size    = size_acc;
          r.size_length  = size_len;
          r.size_unknown = unknown;
          r.is_container = unknown || table_hit(id_acc);
          log_beat(r);
          // Descended elements and empty payloads go straight to the next header.
          if (r.is_container || size_acc == '0) begin
            ph = PH_ID_FIRST;
          end else begin
            pay_left = size_acc;
            ph       = PH_PAYLOAD;
          end
        end
      end
      default: begin
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_last = (pay_left <= 56'd1);
        log_beat(r);
        if (pay_left <= 56'd1) begin
          pay_left = '0;
          ph       = PH_ID_FIRST;
        end else begin
          pay_left = pay_left - 56'd1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v, inout bit bad);
    if (want_v !== got_v) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("%0t: result field %s expected 0x%0h, got 0x%0h", $realtime, name, want_v,
                 got_v);
    end
  endtask

  task automatic check_beat();
    result_t want;
    bit      bad;
    bad = 1'b0;
    if (pending_beats.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result beat of kind %0d arrived with nothing outstanding", $realtime,
                 out_kind);
      mismatches++;
    end else begin
      want = pending_beats.pop_front();
      check_field("kind", want.kind, out_kind, bad);
      check_field("elem_id", want.elem_id, out_elem_id, bad);
      check_field("id_length", want.id_length, out_id_length, bad);
      check_field("data_size", want.data_size, out_data_size, bad);
      check_field("size_length", want.size_length, out_size_length, bad);
      check_field("size_unknown", want.size_unknown, out_size_unknown, bad);
      check_field("is_container", want.is_container, out_is_container, bad);
      check_field("payload_byte", want.payload_byte, out_payload_byte, bad);
      check_field("payload_last", want.payload_last, out_payload_last, bad);
      if (bad) mismatches++;
    end
  endtask

  // Results are checked before the same edge's input byte is predicted, so a
  // beat can never be matched against an expectation raised in its own cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) parse_byte(in_byte);
      if (cfg_valid && cfg_ready) cont_ids[cfg_index] = cfg_data;
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, pending_beats.size());
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Holds the stream off until every outstanding result has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_table();
    wait_idle();
    for (int i = 0; i < NUM_CONT; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= next_table[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    tables_loaded++;
  endtask

  task automatic send_id(input logic [31:0] id, input int id_n);
    for (int i = id_n - 1; i >= 0; i--) send_byte(id[8*i +: 8]);
  endtask

  // One element: ID, size field of size_n bytes, then the payload when the
  // parser will stream it rather than descend.
  task automatic send_element(input logic [31:0] id, input int id_n,
                              input logic [55:0] size, input int size_n);
    logic [63:0] enc;
    bit          descend;
    enc = {8'h00, size} | (64'd1 << (7 * size_n));
    send_id(id, id_n);
    for (int i = size_n - 1; i >= 0; i--) send_byte(enc[8*i +: 8]);
    descend = table_hit(id) || (size == value_ones(size_n));
    if (!descend)
      for (int k = 0; k < int'(size); k++) send_byte(8'($urandom));
  endtask

  task automatic make_id(output logic [31:0] id, output int id_n);
    logic [7:0] mark;
    id_n = $urandom_range(1, MAX_ID_BYTES);
    mark = 8'h80 >> (id_n - 1);
    id   = {24'h0, mark | (8'($urandom) & (mark - 8'h01))};
    for (int i = 1; i < id_n; i++) id = {id[23:0], 8'($urandom)};
  endtask

  // Mostly random IDs, but reuse a table entry when it is a well-formed ID.
  task automatic pick_id(output logic [31:0] id, output int id_n);
    logic [31:0] cand;
    int          n;
    cand = cont_ids[$urandom_range(0, NUM_CONT - 1)];
    n = (cand[31:24] != 0) ? 4 : (cand[23:16] != 0) ? 3 : (cand[15:8] != 0) ? 2 : 1;
    if ($urandom_range(0, 9) < 4 && lead_len(cand[8*n-1 -: 8]) == 4'(n)) begin
      id   = cand;
      id_n = n;
    end else begin
      make_id(id, id_n);
    end
  endtask

  task automatic send_random_element();
    logic [31:0] id;
    logic [55:0] size;
    logic [55:0] ones;
    int          id_n;
    int          size_n;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Bad first ID byte: zero or more than four bytes long.
      send_byte(8'($urandom_range(0, 15)));
    end else begin
      pick_id(id, id_n);
      if (pick < 12) begin
        send_id(id, id_n);
        send_byte(8'h00);
      end else begin
        size_n = $urandom_range(1, MAX_SIZE_BYTES);
        ones   = value_ones(size_n);
        if (table_hit(id)) size = 56'({$urandom, $urandom} & {8'h00, ones});
        else if (pick < 20) size = ones;
        else if (pick < 80) size = 56'($urandom_range(0, 8));
        else size = 56'($urandom_range(9, 40));
        send_element(id, id_n, size, size_n);
      end
    end
  endtask

  task automatic run_stream(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_element();
  endtask

  task automatic test_directed_headers();
    send_byte(8'h00);                                       // zero first ID byte
    send_byte(8'h0F);                                       // five-byte ID
    send_id(32'h80, 1);
    send_byte(8'h00);                                       // zero first size byte
    send_element(32'hFF, 1, 56'h0, 1);                      // empty payload
    send_element(32'h81, 1, 56'h2, 1);                      // two payload beats
    send_element(32'h10FF_FFFF, 4, 56'h7F, 1);              // unknown size, plain ID
    send_element(32'h1A45_DFA3, 4, value_ones(8), 8);       // eight-byte unknown size
    send_element(32'hAE, 1, 56'h12, 1);                     // default container
  endtask

  task automatic test_default_table_stream();
    run_stream(330);
  endtask

  task automatic test_table_extremes();
    for (int i = 0; i < NUM_CONT; i++) next_table[i] = 32'h0000_0000;
    load_table();
    run_stream(120);
    for (int i = 0; i < NUM_CONT; i++) next_table[i] = 32'hFFFF_FFFF;
    load_table();
    run_stream(120);
  endtask

  task automatic test_custom_table_stream();
    logic [31:0] id;
    int          id_n;
    for (int i = 0; i < NUM_CONT; i++) begin
      make_id(id, id_n);
      next_table[i] = id;
    end
    load_table();
    run_stream(125);
    wait_idle();
    run_stream(125);
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < NUM_CONT; i++) next_table[i] = CONT_ID_RESET[i];
    load_table();
    idle_on = 1'b0;
    run_stream(120);
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_headers();
    test_default_table_stream();
    test_table_extremes();
    test_custom_table_stream();
    test_back_to_back();
    wait_idle();

    $display("Streamed %0d bytes: %0d headers, %0d payload beats, %0d malformed headers.",
             bytes_sent, n_headers, n_payload, n_errors);
    $display("Container table loaded %0d times, all-zero and all-ones settings included.",
             tables_loaded);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
